// ----- rtl/selective_ssm_recurrent_step_top_defines.svh -----
// Assertion macros for the selective SSM step block.
`ifndef SELECTIVE_SSM_RECURRENT_STEP_TOP_DEFINES_SVH
`define SELECTIVE_SSM_RECURRENT_STEP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SSSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSSR_ASSERT_SAME(label, ante, cons, msg)
`define SSSR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/sssr_pkg.sv -----
package sssr_pkg;

  localparam logic [2:0] OP_LOAD_DECAY = 3'd0;
  localparam logic [2:0] OP_LOAD_SKIP  = 3'd1;
  localparam logic [2:0] OP_LOAD_BC    = 3'd2;
  localparam logic [2:0] OP_PROCESS    = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic       REG_CHANNELS  = 1'b0;
  localparam logic       REG_STATES    = 1'b1;

  localparam logic [32:0] LOG2E_Q16 = 33'd94548;
  localparam logic [32:0] ONE_Q30   = 33'd1073741824;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SKRD, ST_DX, ST_DXACC, ST_RD, ST_Z, ST_T, ST_TR,
    ST_ROOT, ST_ROOTW, ST_ABAR, ST_KEEP, ST_DB, ST_DBX, ST_H, ST_CH, ST_ACC, ST_Y
  } state_t;

  typedef struct packed {
    logic decay;
    logic skip;
    logic bc;
    logic hid;
  } mem_we_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] vv;
    res = '0;
    bt  = 64'd1 << 62;
    vv  = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= res + bt) begin
        vv  = vv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^-(1/2^(k+1)) in Q1.30, successive floor square roots
  function automatic logic [30:0] root_q30(int k);
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int i = 0; i <= k; i++) r = isqrt64(r << 30);
    return r[30:0];
  endfunction

  localparam logic [30:0] ROOT_TAB [16] = '{
    root_q30(0),  root_q30(1),  root_q30(2),  root_q30(3),
    root_q30(4),  root_q30(5),  root_q30(6),  root_q30(7),
    root_q30(8),  root_q30(9),  root_q30(10), root_q30(11),
    root_q30(12), root_q30(13), root_q30(14), root_q30(15)
  };

  function automatic logic signed [31:0] sat32(logic signed [55:0] v);
    if (v > 56'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -56'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic over32(logic signed [55:0] v);
    return (v > 56'sd2147483647) || (v < -56'sd2147483648);
  endfunction

endpackage

// ----- rtl/selective_ssm_recurrent_step_top.sv -----
// Selective state-space recurrent step, one channel per process item.
// Input channel: in_valid/in_stall with operation, slot, channel, state_index and
// the data fields. Loads (decay rate, skip gain, B/C entry) are written in the
// cycle they are taken. A process item walks states 0..states_in_use-1 (at most
// MAX_STATES) on one shared 33x33 multiplier under a sequencer; each state
// includes the 16-step 2^-f product chain of the exponential. The result is
// held in the last step until the output register is free; the sequencer then
// returns to idle to take the next item, and in_stall stays high until then.
// Output channel: out_valid/out_stall carries y_value, result_slot,
// result_channel and saturated from an output register, one item per process
// item in range; a held result does not block the next input item, only the
// finish of the following process item.
// A clear item zeroes one slot's hidden state, one entry a cycle. After
// reset the whole hidden store is swept the same way before the first item
// is taken; configuration writes are taken at any time.
`include "selective_ssm_recurrent_step_top_defines.svh"
module selective_ssm_recurrent_step_top #(
  parameter int MAX_SLOTS    = 4,
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_STATES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [1:0]  slot,
  input  logic [7:0]  channel,
  input  logic [3:0]  state_index,
  input  logic [15:0] decay_rate,
  input  logic signed [15:0] skip_gain,
  input  logic signed [15:0] input_b,
  input  logic signed [15:0] input_c,
  input  logic signed [15:0] sample_x,
  input  logic [15:0] step_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] y_value,
  output logic [1:0]  result_slot,
  output logic [7:0]  result_channel,
  output logic        saturated
);
  localparam int DAW = (MAX_CHANNELS * MAX_STATES > 1) ? $clog2(MAX_CHANNELS * MAX_STATES) : 1;
  localparam int CAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BAW = (MAX_SLOTS * MAX_STATES > 1) ? $clog2(MAX_SLOTS * MAX_STATES) : 1;
  localparam int SLOT_SIZE = MAX_CHANNELS * MAX_STATES;
  localparam int HN  = MAX_SLOTS * SLOT_SIZE;
  localparam int HAW = (HN > 1) ? $clog2(HN) : 1;
  localparam int JW  = $clog2(MAX_STATES + 1);

  sssr_pkg::state_t state, state_next;

  // configuration
  logic [8:0] channels_in_use;
  logic [4:0] states_in_use;

  // per-item registers
  logic [1:0]  slot_r;
  logic [7:0]  ch_r;
  logic signed [15:0] x_r;
  logic [15:0] delta_r;
  logic [JW-1:0] nst_r;
  logic [JW-1:0] j;
  logic [3:0]  k;
  logic [13:0] n_r;
  logic [15:0] f_r;
  logic [30:0] m;
  logic [16:0] abar;
  logic signed [33:0] keep;
  logic signed [31:0] hn;
  logic signed [55:0] acc;
  logic        flag;
  logic [HAW-1:0] sweep_addr, sweep_last;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // storage
  sssr_pkg::mem_we_t we;
  logic [15:0] decay_q, skip_q, b_q, c_q;
  logic [31:0] h_q;
  logic [HAW-1:0] hid_addr, hid_waddr;
  logic [31:0] hid_wdata;

  logic accept, in_range_proc, out_free;

  // datapath terms
  logic [49:0] tsum;
  logic [60:0] msum;
  logic [5:0]  sh;
  logic [63:0] abar_wide;
  logic signed [65:0] keep_sum, drv_sum;
  logic signed [27:0] drive;
  logic signed [34:0] hsum;
  logic signed [55:0] ysum;
  logic signed [55:0] yshift;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range_proc = (32'(slot) < MAX_SLOTS) && (32'(channel) < MAX_CHANNELS)
                         && ({1'b0, channel} < channels_in_use);
  assign hid_addr = HAW'((32'(slot_r) * MAX_CHANNELS + 32'(ch_r)) * MAX_STATES + 32'(j));

  sssr_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  sssr_mem #(
    .MAX_SLOTS    (MAX_SLOTS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_STATES   (MAX_STATES)
  ) u_mem (
    .clk         (clk),
    .we          (we),
    .decay_waddr (DAW'(32'(channel) * MAX_STATES + 32'(state_index))),
    .decay_raddr (DAW'(32'(ch_r) * MAX_STATES + 32'(j))),
    .decay_wdata (decay_rate),
    .decay_rdata (decay_q),
    .skip_waddr  (CAW'(32'(channel))),
    .skip_raddr  (CAW'(32'(ch_r))),
    .skip_wdata  (skip_gain),
    .skip_rdata  (skip_q),
    .bc_waddr    (BAW'(32'(slot) * MAX_STATES + 32'(state_index))),
    .bc_raddr    (BAW'(32'(slot_r) * MAX_STATES + 32'(j))),
    .b_wdata     (input_b),
    .c_wdata     (input_c),
    .b_rdata     (b_q),
    .c_rdata     (c_q),
    .hid_waddr   (hid_waddr),
    .hid_raddr   (hid_addr),
    .hid_wdata   (hid_wdata),
    .hid_rdata   (h_q)
  );

  // arithmetic around the multiplier
  always_comb begin
    tsum      = prod[49:0] + 50'd32768;               // round(z*log2e / 2^16)
    msum      = prod[60:0] + 61'd536870912;           // round by 2^30
    sh        = 6'(n_r) + 6'd14;
    abar_wide = (64'(m) + (64'd1 << (sh - 6'd1))) >> sh;
    keep_sum  = prod + 66'sd32768;
    drv_sum   = prod + 66'sd524288;
    drive     = drv_sum[47:20];
    hsum      = 35'(keep) + 35'(drive);
    ysum      = acc + 56'sd2048;
    yshift    = ysum >>> 12;
  end

  function automatic logic [31:0] hn_next_w();
    return sssr_pkg::sat32(56'(hsum));
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sssr_pkg::ST_CLEAR: if (sweep_addr == sweep_last) state_next = sssr_pkg::ST_IDLE;
      sssr_pkg::ST_IDLE: begin
        if (accept && operation == sssr_pkg::OP_PROCESS && in_range_proc)
          state_next = sssr_pkg::ST_SKRD;
        else if (accept && operation == sssr_pkg::OP_CLEAR && 32'(slot) < MAX_SLOTS)
          state_next = sssr_pkg::ST_CLEAR;
      end
      sssr_pkg::ST_SKRD:  state_next = sssr_pkg::ST_DX;
      sssr_pkg::ST_DX:    state_next = sssr_pkg::ST_DXACC;
      sssr_pkg::ST_DXACC: state_next = (nst_r == '0) ? sssr_pkg::ST_Y : sssr_pkg::ST_RD;
      sssr_pkg::ST_RD:    state_next = sssr_pkg::ST_Z;
      sssr_pkg::ST_Z:     state_next = sssr_pkg::ST_T;
      sssr_pkg::ST_T:     state_next = sssr_pkg::ST_TR;
      sssr_pkg::ST_TR:    state_next = sssr_pkg::ST_ROOT;
      sssr_pkg::ST_ROOT:  state_next = sssr_pkg::ST_ROOTW;
      sssr_pkg::ST_ROOTW: state_next = (k == 4'd15) ? sssr_pkg::ST_ABAR : sssr_pkg::ST_ROOT;
      sssr_pkg::ST_ABAR:  state_next = sssr_pkg::ST_KEEP;
      sssr_pkg::ST_KEEP:  state_next = sssr_pkg::ST_DB;
      sssr_pkg::ST_DB:    state_next = sssr_pkg::ST_DBX;
      sssr_pkg::ST_DBX:   state_next = sssr_pkg::ST_H;
      sssr_pkg::ST_H:     state_next = sssr_pkg::ST_CH;
      sssr_pkg::ST_CH:    state_next = sssr_pkg::ST_ACC;
      sssr_pkg::ST_ACC:   state_next = (j + JW'(1) == nst_r) ? sssr_pkg::ST_Y : sssr_pkg::ST_RD;
      sssr_pkg::ST_Y:     if (out_free) state_next = sssr_pkg::ST_IDLE;
      default:            state_next = sssr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: operand select, store writes, input stall
  always_comb begin
    in_stall  = (state != sssr_pkg::ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    we        = '0;
    hid_waddr = hid_addr;
    hid_wdata = hn_next_w();
    unique case (state)
      sssr_pkg::ST_CLEAR: begin
        we.hid    = 1'b1;
        hid_waddr = sweep_addr;
        hid_wdata = '0;
      end
      sssr_pkg::ST_IDLE: begin
        we.decay = accept && operation == sssr_pkg::OP_LOAD_DECAY
                   && 32'(channel) < MAX_CHANNELS && 32'(state_index) < MAX_STATES;
        we.skip  = accept && operation == sssr_pkg::OP_LOAD_SKIP
                   && 32'(channel) < MAX_CHANNELS;
        we.bc    = accept && operation == sssr_pkg::OP_LOAD_BC
                   && 32'(slot) < MAX_SLOTS && 32'(state_index) < MAX_STATES;
      end
      sssr_pkg::ST_DX: begin
        mul_a = 33'($signed(skip_q));
        mul_b = 33'(x_r);
      end
      sssr_pkg::ST_Z: begin
        mul_a = {17'd0, delta_r};
        mul_b = {17'd0, decay_q};
      end
      sssr_pkg::ST_T: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = sssr_pkg::LOG2E_Q16;
      end
      sssr_pkg::ST_ROOT: begin
        mul_a = {2'd0, m};
        mul_b = f_r[4'd15 - k] ? {2'd0, sssr_pkg::ROOT_TAB[k]} : sssr_pkg::ONE_Q30;
      end
      sssr_pkg::ST_KEEP: begin
        mul_a = {16'd0, abar};
        mul_b = 33'($signed(h_q));
      end
      sssr_pkg::ST_DB: begin
        mul_a = {17'd0, delta_r};
        mul_b = 33'($signed(b_q));
      end
      sssr_pkg::ST_DBX: begin
        mul_a = prod[32:0];
        mul_b = 33'(x_r);
      end
      sssr_pkg::ST_H: we.hid = 1'b1;
      sssr_pkg::ST_CH: begin
        mul_a = 33'($signed(c_q));
        mul_b = 33'(hn);
      end
      default: ;
    endcase
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= sssr_pkg::ST_CLEAR;
      sweep_addr      <= '0;
      sweep_last      <= HAW'(HN - 1);
      channels_in_use <= 9'd256;
      states_in_use   <= 5'd16;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          sssr_pkg::REG_CHANNELS: channels_in_use <= cfg_data;
          sssr_pkg::REG_STATES:   states_in_use   <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state == sssr_pkg::ST_CLEAR) begin
        sweep_addr <= sweep_addr + HAW'(1);
      end else if (state == sssr_pkg::ST_IDLE && accept && operation == sssr_pkg::OP_CLEAR) begin
        sweep_addr <= HAW'(32'(slot) * SLOT_SIZE);
        sweep_last <= HAW'(32'(slot) * SLOT_SIZE + SLOT_SIZE - 1);
      end
      if (state == sssr_pkg::ST_Y && out_free)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      sssr_pkg::ST_IDLE: begin
        slot_r  <= slot;
        ch_r    <= channel;
        x_r     <= sample_x;
        delta_r <= step_size;
        nst_r   <= (32'(states_in_use) < MAX_STATES) ? JW'(states_in_use) : JW'(MAX_STATES);
        flag    <= 1'b0;
        j       <= '0;
      end
      sssr_pkg::ST_DXACC: acc <= 56'(prod) <<< 4;
      sssr_pkg::ST_TR: begin
        n_r <= tsum[49:36];
        f_r <= tsum[35:20];
        m   <= 31'd1073741824;
        k   <= '0;
      end
      sssr_pkg::ST_ROOTW: begin
        m <= msum[60:30];
        k <= k + 4'd1;
      end
      sssr_pkg::ST_ABAR: abar <= (n_r > 14'd40) ? 17'd0 : abar_wide[16:0];
      sssr_pkg::ST_DB:   keep <= keep_sum[49:16];
      sssr_pkg::ST_H: begin
        hn   <= hn_next_w();
        flag <= flag | sssr_pkg::over32(56'(hsum));
      end
      sssr_pkg::ST_ACC: begin
        acc <= acc + 56'(prod);
        j   <= j + JW'(1);
      end
      sssr_pkg::ST_Y: begin
        if (out_free) begin
          y_value        <= sssr_pkg::sat32(yshift);
          result_slot    <= slot_r;
          result_channel <= ch_r;
          saturated      <= flag | sssr_pkg::over32(yshift);
        end
      end
      default: ;
    endcase
  end

  // the root chain always runs sixteen steps before the decay factor
  `SSSR_ASSERT_NEXT(a_root_len, state == sssr_pkg::ST_ROOTW && k == 4'd15, state == sssr_pkg::ST_ABAR, "root chain length")
  // a large exponent gives a zero decay factor
  `SSSR_ASSERT_NEXT(a_abar_zero, state == sssr_pkg::ST_ABAR && n_r > 14'd40, abar == 17'd0, "abar not zero")
  // a finished item is shown at once when the output register is free
  `SSSR_ASSERT_NEXT(a_finish, state == sssr_pkg::ST_Y && out_free, out_valid && state == sssr_pkg::ST_IDLE, "result not shown")
  // the store is never written from a load while the sequencer is busy
  `SSSR_ASSERT_SAME(a_load_idle, we.decay || we.skip || we.bc, state == sssr_pkg::ST_IDLE, "load while busy")

endmodule

// ----- rtl/sssr_mul.sv -----
// Shared signed multiplier, product registered.
module sssr_mul (
  input  logic               clk,
  input  logic signed [32:0] mul_a,
  input  logic signed [32:0] mul_b,
  output logic signed [65:0] prod
);
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end
endmodule

// ----- rtl/sssr_mem.sv -----
// Table and hidden-state storage; all reads registered.
module sssr_mem #(
  parameter int MAX_SLOTS    = 4,
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_STATES   = 16,
  localparam int DAW = (MAX_CHANNELS * MAX_STATES > 1) ? $clog2(MAX_CHANNELS * MAX_STATES) : 1,
  localparam int CAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int BAW = (MAX_SLOTS * MAX_STATES > 1) ? $clog2(MAX_SLOTS * MAX_STATES) : 1,
  localparam int HN  = MAX_SLOTS * MAX_CHANNELS * MAX_STATES,
  localparam int HAW = (HN > 1) ? $clog2(HN) : 1
) (
  input  logic             clk,
  input  sssr_pkg::mem_we_t we,
  input  logic [DAW-1:0]   decay_waddr,
  input  logic [DAW-1:0]   decay_raddr,
  input  logic [15:0]      decay_wdata,
  output logic [15:0]      decay_rdata,
  input  logic [CAW-1:0]   skip_waddr,
  input  logic [CAW-1:0]   skip_raddr,
  input  logic [15:0]      skip_wdata,
  output logic [15:0]      skip_rdata,
  input  logic [BAW-1:0]   bc_waddr,
  input  logic [BAW-1:0]   bc_raddr,
  input  logic [15:0]      b_wdata,
  input  logic [15:0]      c_wdata,
  output logic [15:0]      b_rdata,
  output logic [15:0]      c_rdata,
  input  logic [HAW-1:0]   hid_waddr,
  input  logic [HAW-1:0]   hid_raddr,
  input  logic [31:0]      hid_wdata,
  output logic [31:0]      hid_rdata
);
  logic [15:0] decay_mem [MAX_CHANNELS * MAX_STATES];
  logic [15:0] skip_mem  [MAX_CHANNELS];
  logic [15:0] b_mem     [MAX_SLOTS * MAX_STATES];
  logic [15:0] c_mem     [MAX_SLOTS * MAX_STATES];
  logic [31:0] hid_mem   [HN];

  always_ff @(posedge clk) begin
    if (we.decay) decay_mem[decay_waddr] <= decay_wdata;
    decay_rdata <= decay_mem[decay_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.skip) skip_mem[skip_waddr] <= skip_wdata;
    skip_rdata <= skip_mem[skip_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.bc) begin
      b_mem[bc_waddr] <= b_wdata;
      c_mem[bc_waddr] <= c_wdata;
    end
    b_rdata <= b_mem[bc_raddr];
    c_rdata <= c_mem[bc_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.hid) hid_mem[hid_waddr] <= hid_wdata;
    hid_rdata <= hid_mem[hid_raddr];
  end
endmodule
